[sv/i2c_ras_pkg.sv]
// ----------------------------------------------------------------------------
// i2c_ras_pkg: shared types and codes of the I2C register access sequencer
// Field layouts of the request and result beats, core command and status
// codes, queue sizes and the records passed between front, back and output.
// ----------------------------------------------------------------------------
package i2c_ras_pkg;

	// queue sizes
	localparam int XFER_DEPTH  = 4;
	localparam int WDATA_DEPTH = 16;
	localparam int FQ_DEPTH    = 2;
	localparam int MAX_RES     = 3;

	localparam int XQ_PW  = (XFER_DEPTH > 1) ? $clog2(XFER_DEPTH) : 1;
	localparam int XQ_CW  = $clog2(XFER_DEPTH + 1);
	localparam int WQ_PW  = (WDATA_DEPTH > 1) ? $clog2(WDATA_DEPTH) : 1;
	localparam int WQ_CW  = $clog2(WDATA_DEPTH + 1);
	localparam int WQ_SW  = WQ_CW + 1;
	localparam int WQ_DW  = (WQ_CW > 8) ? WQ_CW : 8;
	localparam int FQ_PW  = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
	localparam int FQ_CW  = $clog2(FQ_DEPTH + 1);
	localparam int RES_CW = $clog2(MAX_RES + 1);

	// request types
	localparam logic [1:0] REQ_XFER  = 2'd0;
	localparam logic [1:0] REQ_WBYTE = 2'd1;
	localparam logic [1:0] REQ_EVENT = 2'd2;

	// core event codes
	localparam logic [2:0] EV_START    = 3'd0;
	localparam logic [2:0] EV_ADDR_TX  = 3'd1;
	localparam logic [2:0] EV_ADDR_RX  = 3'd2;
	localparam logic [2:0] EV_BYTE_TX  = 3'd3;
	localparam logic [2:0] EV_BYTE_RX  = 3'd4;
	localparam logic [2:0] EV_NACK     = 3'd5;
	localparam logic [2:0] EV_ERROR    = 3'd6;
	localparam logic [2:0] EV_INVALID  = 3'd7;

	// core commands
	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_START   = 3'd1;
	localparam logic [2:0] CMD_ADDR_W  = 3'd2;
	localparam logic [2:0] CMD_ADDR_R  = 3'd3;
	localparam logic [2:0] CMD_SEND    = 3'd4;
	localparam logic [2:0] CMD_STOP    = 3'd5;
	localparam logic [2:0] CMD_ACK_ON  = 3'd6;
	localparam logic [2:0] CMD_ACK_OFF = 3'd7;

	// status codes
	localparam logic [2:0] STAT_NONE    = 3'd0;
	localparam logic [2:0] STAT_DONE    = 3'd1;
	localparam logic [2:0] STAT_NOSLAVE = 3'd2;
	localparam logic [2:0] STAT_DROPPED = 3'd3;
	localparam logic [2:0] STAT_FAULT   = 3'd4;
	localparam logic [2:0] STAT_MISSING = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MASTER_REQ,
		S_ADDRESSED,
		S_ADDR_TXED,
		S_REPEAT_START,
		S_REPEAT_ADDR,
		S_READING,
		S_WRITING,
		S_CLOSING
	} seq_state_t;

	typedef enum logic [1:0] {
		K_XFER,
		K_WBYTE,
		K_EVENT,
		K_OTHER
	} kind_t;

	typedef enum logic [4:0] {
		ACT_NONE,
		ACT_HOLD,
		ACT_RAISE,
		ACT_BEGIN,
		ACT_DROP,
		ACT_ENQ_XFER,
		ACT_ENQ_BYTE,
		ACT_NOSLAVE,
		ACT_ADDR_W,
		ACT_REG,
		ACT_RESTART,
		ACT_ADDR_R,
		ACT_RX_ADDR,
		ACT_RX_BYTE,
		ACT_MISSING,
		ACT_SEND,
		ACT_CLOSE
	} act_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       xfer_op;
		logic [7:0] dev_addr;
		logic [7:0] reg_addr;
		logic [7:0] byte_count;
		logic [7:0] write_byte;
		logic [2:0] event_code;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [2:0] core_cmd;
		logic [7:0] cmd_byte;
		logic       read_valid;
		logic [7:0] read_byte;
		logic [2:0] status;
		logic       last;
	} res_t;

	typedef struct packed {
		logic       op;
		logic [7:0] dev_addr;
		logic [7:0] reg_addr;
		logic [7:0] byte_count;
	} xfer_t;

	typedef struct packed {
		kind_t      kind;
		xfer_t      xfer;
		logic [7:0] wbyte;
		logic [2:0] ev;
		logic [7:0] rx;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} fq_head_t;

	typedef struct packed {
		logic                      load;
		logic [RES_CW-1:0]         n;
		res_t [MAX_RES-1:0]        slot;
	} res_bundle_t;

	function automatic res_t mk_res(input logic [2:0] cmd, input logic [7:0] cb,
			input logic rv, input logic [7:0] rb, input logic [2:0] st);
		res_t r;
		r.core_cmd   = cmd;
		r.cmd_byte   = cb;
		r.read_valid = rv;
		r.read_byte  = rb;
		r.status     = st;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

[sv/i2c_ras_req_if.sv]
// ----------------------------------------------------------------------------
// i2c_ras_req_if: request channel
// Valid/ready channel carrying one request beat of the sequencer.
// ----------------------------------------------------------------------------
interface i2c_ras_req_if import i2c_ras_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/i2c_ras_res_if.sv]
// ----------------------------------------------------------------------------
// i2c_ras_res_if: result channel
// Valid/ready channel carrying one result beat (core command and status).
// ----------------------------------------------------------------------------
interface i2c_ras_res_if import i2c_ras_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/i2c_ras_front.sv]
// ----------------------------------------------------------------------------
// i2c_ras_front: request intake
// Accepts request beats, classifies them and holds them in a short queue
// until the sequencer takes them.
// ----------------------------------------------------------------------------
module i2c_ras_front import i2c_ras_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	i2c_ras_req_if.sink  req,
	input  logic         pop,
	output fq_head_t     head
);

	item_t             cls;
	item_t             fq_q [FQ_DEPTH];
	logic [FQ_PW-1:0]  rd_q;
	logic [FQ_PW-1:0]  wr_q;
	logic [FQ_CW-1:0]  cnt_q;
	logic              push;
	logic              take;

	always_comb begin
		cls.xfer.op         = req.data.xfer_op;
		cls.xfer.dev_addr   = req.data.dev_addr;
		cls.xfer.reg_addr   = req.data.reg_addr;
		// a zero count runs as one byte
		cls.xfer.byte_count = (req.data.byte_count == 8'd0) ? 8'd1 : req.data.byte_count;
		cls.wbyte           = req.data.write_byte;
		cls.ev              = req.data.event_code;
		cls.rx              = req.data.rx_byte;
		unique case (req.data.req_type)
			REQ_XFER:  cls.kind = K_XFER;
			REQ_WBYTE: cls.kind = K_WBYTE;
			REQ_EVENT: cls.kind = (req.data.event_code == EV_INVALID) ? K_OTHER : K_EVENT;
			default:   cls.kind = K_OTHER;
		endcase
	end

	assign req.ready  = (cnt_q != FQ_CW'(FQ_DEPTH));
	assign push       = req.valid && req.ready;
	assign head.valid = (cnt_q != '0);
	assign head.item  = fq_q[rd_q];
	assign take       = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == FQ_PW'(FQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (take) begin
				rd_q <= (rd_q == FQ_PW'(FQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fq_q[wr_q] <= cls;
		end
	end

endmodule

[sv/i2c_ras_seq.sv]
// ----------------------------------------------------------------------------
// i2c_ras_seq: transfer sequencer
// Holds the transfer and write data queues and the I2C sequence state, and
// turns each request into up to three result beats for the output buffer.
// ----------------------------------------------------------------------------
module i2c_ras_seq import i2c_ras_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  fq_head_t    head,
	output logic        pop,
	input  logic        can_load,
	output res_bundle_t bundle
);

	item_t             it;
	act_t              act;

	seq_state_t        state_q, state_d;
	logic              busy_q, busy_d;
	logic              op_q, op_d;
	logic [7:0]        dev_q, dev_d;
	logic [7:0]        reg_q, reg_d;
	logic [7:0]        left_q, left_d;
	logic              fault_q, fault_d;

	xfer_t             xq_q [XFER_DEPTH];
	logic [XQ_PW-1:0]  xq_rd_q, xq_rd_d, xq_wr_q, xq_wr_d;
	logic [XQ_CW-1:0]  xq_cnt_q, xq_cnt_d;
	logic              xq_push;

	logic [7:0]        wq_q [WDATA_DEPTH];
	logic [WQ_PW-1:0]  wq_rd_q, wq_rd_d, wq_wr_q, wq_wr_d;
	logic [WQ_CW-1:0]  wq_cnt_q, wq_cnt_d;
	logic              wq_push;

	logic [7:0]        left_dec;
	logic              next_ok;
	logic              does_next;
	xfer_t             nxt;
	logic [WQ_CW-1:0]  drop_n;
	logic [WQ_SW-1:0]  drop_sum;

	logic [RES_CW-1:0] n;
	res_t [MAX_RES-1:0] slot;

	assign it       = head.item;
	assign pop      = head.valid && can_load;
	assign left_dec = left_q - 8'd1;
	assign next_ok  = (xq_cnt_q != '0);
	assign nxt      = xq_q[xq_rd_q];

	// classify the request against the current sequence state
	always_comb begin
		act = ACT_NONE;
		if (fault_q) begin
			act = ACT_HOLD;
		end else begin
			unique case (it.kind)
				K_XFER: begin
					if (!busy_q) act = ACT_BEGIN;
					else if (xq_cnt_q == XQ_CW'(XFER_DEPTH)) act = ACT_DROP;
					else act = ACT_ENQ_XFER;
				end
				K_WBYTE: begin
					act = (wq_cnt_q == WQ_CW'(WDATA_DEPTH)) ? ACT_DROP : ACT_ENQ_BYTE;
				end
				K_EVENT: begin
					if (busy_q) begin
						if (it.ev == EV_ERROR) begin
							act = ACT_RAISE;
						end else if (it.ev == EV_NACK) begin
							act = (!op_q && state_q == S_ADDRESSED) ? ACT_NOSLAVE : ACT_RAISE;
						end else begin
							unique case (state_q)
								S_MASTER_REQ:   if (it.ev == EV_START) act = ACT_ADDR_W;
								S_ADDRESSED:    if (it.ev == EV_ADDR_TX) act = ACT_REG;
								S_ADDR_TXED:    if (it.ev == EV_BYTE_TX) act = ACT_RESTART;
								S_REPEAT_START: if (it.ev == EV_START) act = ACT_ADDR_R;
								S_REPEAT_ADDR:  if (it.ev == EV_ADDR_RX) act = ACT_RX_ADDR;
								S_READING:      if (it.ev == EV_BYTE_RX) act = ACT_RX_BYTE;
								S_WRITING: begin
									if (it.ev == EV_BYTE_TX) begin
										act = (wq_cnt_q == '0) ? ACT_MISSING : ACT_SEND;
									end
								end
								S_CLOSING:      act = ACT_CLOSE;
								default:        act = ACT_NONE;
							endcase
						end
					end
				end
				default: act = ACT_NONE;
			endcase
		end
	end

	assign does_next = (act == ACT_NOSLAVE) || (act == ACT_MISSING) || (act == ACT_CLOSE)
		|| ((act == ACT_RX_BYTE) && (left_dec == 8'd0));

	// bytes discarded after an address NACK: the smaller of bytes left and fill
	always_comb begin
		if (WQ_DW'(left_q) < WQ_DW'(wq_cnt_q)) drop_n = WQ_CW'(left_q);
		else drop_n = wq_cnt_q;
		drop_sum = WQ_SW'(wq_rd_q) + WQ_SW'(drop_n);
		if (drop_sum >= WQ_SW'(WDATA_DEPTH)) drop_sum = drop_sum - WQ_SW'(WDATA_DEPTH);
	end

	// next state
	always_comb begin
		state_d  = state_q;
		busy_d   = busy_q;
		op_d     = op_q;
		dev_d    = dev_q;
		reg_d    = reg_q;
		left_d   = left_q;
		fault_d  = fault_q;
		xq_rd_d  = xq_rd_q;
		xq_wr_d  = xq_wr_q;
		xq_cnt_d = xq_cnt_q;
		wq_rd_d  = wq_rd_q;
		wq_wr_d  = wq_wr_q;
		wq_cnt_d = wq_cnt_q;
		xq_push  = 1'b0;
		wq_push  = 1'b0;
		unique case (act)
			ACT_RAISE: fault_d = 1'b1;
			ACT_ENQ_XFER: begin
				xq_push  = 1'b1;
				xq_wr_d  = (xq_wr_q == XQ_PW'(XFER_DEPTH - 1)) ? '0 : xq_wr_q + 1'b1;
				xq_cnt_d = xq_cnt_q + 1'b1;
			end
			ACT_ENQ_BYTE: begin
				wq_push  = 1'b1;
				wq_wr_d  = (wq_wr_q == WQ_PW'(WDATA_DEPTH - 1)) ? '0 : wq_wr_q + 1'b1;
				wq_cnt_d = wq_cnt_q + 1'b1;
			end
			ACT_NOSLAVE: begin
				wq_rd_d  = WQ_PW'(drop_sum);
				wq_cnt_d = wq_cnt_q - drop_n;
			end
			ACT_ADDR_W:  state_d = S_ADDRESSED;
			ACT_REG:     state_d = op_q ? S_ADDR_TXED : S_WRITING;
			ACT_RESTART: state_d = S_REPEAT_START;
			ACT_ADDR_R:  state_d = S_REPEAT_ADDR;
			ACT_RX_ADDR: state_d = S_READING;
			ACT_RX_BYTE: left_d = left_dec;
			ACT_SEND: begin
				wq_rd_d  = (wq_rd_q == WQ_PW'(WDATA_DEPTH - 1)) ? '0 : wq_rd_q + 1'b1;
				wq_cnt_d = wq_cnt_q - 1'b1;
				left_d   = left_dec;
				if (left_dec == 8'd0) state_d = S_CLOSING;
			end
			default: ;
		endcase
		if (does_next) begin
			busy_d  = 1'b0;
			state_d = S_IDLE;
			if (next_ok) begin
				xq_rd_d  = (xq_rd_q == XQ_PW'(XFER_DEPTH - 1)) ? '0 : xq_rd_q + 1'b1;
				xq_cnt_d = xq_cnt_q - 1'b1;
				op_d     = nxt.op;
				dev_d    = nxt.dev_addr;
				reg_d    = nxt.reg_addr;
				left_d   = nxt.byte_count;
				busy_d   = 1'b1;
				state_d  = S_MASTER_REQ;
			end
		end
		if (act == ACT_BEGIN) begin
			op_d    = it.xfer.op;
			dev_d   = it.xfer.dev_addr;
			reg_d   = it.xfer.reg_addr;
			left_d  = it.xfer.byte_count;
			busy_d  = 1'b1;
			state_d = S_MASTER_REQ;
		end
	end

	// result beats
	always_comb begin
		n    = '0;
		slot = '0;
		unique case (act) inside
			ACT_HOLD, ACT_RAISE: begin
				slot[n] = mk_res(CMD_NONE, 8'd0, 1'b0, 8'd0, STAT_FAULT);
				n = n + 1'b1;
			end
			ACT_DROP: begin
				slot[n] = mk_res(CMD_NONE, 8'd0, 1'b0, 8'd0, STAT_DROPPED);
				n = n + 1'b1;
			end
			ACT_BEGIN: begin
				slot[n] = mk_res(CMD_ACK_ON, 8'd0, 1'b0, 8'd0, STAT_NONE);
				n = n + 1'b1;
				slot[n] = mk_res(CMD_START, 8'd0, 1'b0, 8'd0, STAT_NONE);
				n = n + 1'b1;
			end
			ACT_NOSLAVE: begin
				slot[n] = mk_res(CMD_STOP, 8'd0, 1'b0, 8'd0, STAT_NOSLAVE);
				n = n + 1'b1;
			end
			ACT_ADDR_W: begin
				if (op_q) begin
					slot[n] = mk_res(CMD_ACK_ON, 8'd0, 1'b0, 8'd0, STAT_NONE);
					n = n + 1'b1;
				end
				slot[n] = mk_res(CMD_ADDR_W, dev_q, 1'b0, 8'd0, STAT_NONE);
				n = n + 1'b1;
			end
			ACT_REG: begin
				slot[n] = mk_res(CMD_SEND, reg_q, 1'b0, 8'd0, STAT_NONE);
				n = n + 1'b1;
			end
			ACT_RESTART: begin
				slot[n] = mk_res(CMD_START, 8'd0, 1'b0, 8'd0, STAT_NONE);
				n = n + 1'b1;
			end
			ACT_ADDR_R: begin
				slot[n] = mk_res(CMD_ADDR_R, dev_q, 1'b0, 8'd0, STAT_NONE);
				n = n + 1'b1;
			end
			ACT_RX_ADDR: begin
				// single byte read: NACK it from the start
				if (left_q == 8'd1) begin
					slot[n] = mk_res(CMD_ACK_OFF, 8'd0, 1'b0, 8'd0, STAT_NONE);
					n = n + 1'b1;
				end
			end
			ACT_RX_BYTE: begin
				if (left_dec == 8'd1) begin
					slot[n] = mk_res(CMD_ACK_OFF, 8'd0, 1'b1, it.rx, STAT_NONE);
				end else if (left_dec == 8'd0) begin
					slot[n] = mk_res(CMD_STOP, 8'd0, 1'b1, it.rx, STAT_DONE);
				end else begin
					slot[n] = mk_res(CMD_NONE, 8'd0, 1'b1, it.rx, STAT_NONE);
				end
				n = n + 1'b1;
			end
			ACT_MISSING: begin
				slot[n] = mk_res(CMD_STOP, 8'd0, 1'b0, 8'd0, STAT_MISSING);
				n = n + 1'b1;
			end
			ACT_SEND: begin
				slot[n] = mk_res(CMD_SEND, wq_q[wq_rd_q], 1'b0, 8'd0, STAT_NONE);
				n = n + 1'b1;
				if (left_dec == 8'd0) begin
					slot[n] = mk_res(CMD_STOP, 8'd0, 1'b0, 8'd0, STAT_NONE);
					n = n + 1'b1;
				end
			end
			ACT_CLOSE: begin
				slot[n] = mk_res(CMD_NONE, 8'd0, 1'b0, 8'd0, STAT_DONE);
				n = n + 1'b1;
			end
			default: ;
		endcase
		// chain straight into the next queued transfer
		if (does_next && next_ok) begin
			slot[n] = mk_res(CMD_ACK_ON, 8'd0, 1'b0, 8'd0, STAT_NONE);
			n = n + 1'b1;
			slot[n] = mk_res(CMD_START, 8'd0, 1'b0, 8'd0, STAT_NONE);
			n = n + 1'b1;
		end
		if (n != '0) begin
			slot[n - 1'b1].last = 1'b1;
		end
	end

	assign bundle.load = pop;
	assign bundle.n    = n;
	assign bundle.slot = slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			busy_q   <= 1'b0;
			op_q     <= 1'b0;
			dev_q    <= 8'd0;
			reg_q    <= 8'd0;
			left_q   <= 8'd0;
			fault_q  <= 1'b0;
			xq_rd_q  <= '0;
			xq_wr_q  <= '0;
			xq_cnt_q <= '0;
			wq_rd_q  <= '0;
			wq_wr_q  <= '0;
			wq_cnt_q <= '0;
		end else if (pop) begin
			state_q  <= state_d;
			busy_q   <= busy_d;
			op_q     <= op_d;
			dev_q    <= dev_d;
			reg_q    <= reg_d;
			left_q   <= left_d;
			fault_q  <= fault_d;
			xq_rd_q  <= xq_rd_d;
			xq_wr_q  <= xq_wr_d;
			xq_cnt_q <= xq_cnt_d;
			wq_rd_q  <= wq_rd_d;
			wq_wr_q  <= wq_wr_d;
			wq_cnt_q <= wq_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && xq_push) begin
			xq_q[xq_wr_q] <= it.xfer;
		end
		if (pop && wq_push) begin
			wq_q[wq_wr_q] <= it.wbyte;
		end
	end

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |=> fault_q)
		else $error("fault cleared without reset");

	a_idle_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q != (state_q == S_IDLE))
		else $error("busy flag disagrees with sequence state");

	a_idle_queue_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (xq_cnt_q == '0))
		else $error("transfers queued while sequencer idle");

	a_wq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wq_cnt_q <= WQ_CW'(WDATA_DEPTH))
		else $error("write data fill count overflow");

endmodule

[sv/i2c_ras_outbuf.sv]
// ----------------------------------------------------------------------------
// i2c_ras_outbuf: result buffer
// Holds a request's result beats; hands one out per cycle while res is ready.
// ----------------------------------------------------------------------------
module i2c_ras_outbuf import i2c_ras_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  res_bundle_t   bundle,
	output logic          can_load,
	i2c_ras_res_if.source res
);

	res_t [MAX_RES-1:0] slot_q;
	logic [RES_CW-1:0]  head_q;
	logic [RES_CW-1:0]  left_q;
	logic               take;

	assign res.valid = (left_q != '0);
	assign res.data  = slot_q[head_q];
	assign take      = res.valid && res.ready;
	// refill as the last beat leaves
	assign can_load  = (left_q == '0) || ((left_q == RES_CW'(1)) && res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			left_q <= '0;
		end else if (bundle.load) begin
			head_q <= '0;
			left_q <= bundle.n;
		end else if (take) begin
			head_q <= head_q + 1'b1;
			left_q <= left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bundle.load) begin
			slot_q <= bundle.slot;
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		bundle.load |-> can_load)
		else $error("result buffer overwritten while beats pending");

	a_last_marks_final: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.data.last == (left_q == RES_CW'(1))))
		else $error("last flag not on the final beat of a request");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, head_q} + {1'b0, left_q}) <= (RES_CW + 1)'(MAX_RES))
		else $error("result buffer index beyond its slots");

endmodule

[sv/i2c_register_access_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer_unit: I2C register read/write sequencer
// Queues register transfers and steps an I2C master core through them.
// ----------------------------------------------------------------------------
// Usage:
//   req carries host requests: queue a transfer, push a write data byte, or
//   report a core event. res carries core commands, received bytes and
//   status; last marks the final result beat of each request beat.
//   A request beat enters a two-entry intake queue, so req stays ready while
//   results wait. The sequencer takes one request per cycle from that queue
//   whenever the output buffer can load, and loads its zero to three result
//   beats into it. The buffer hands out its beats in order while res is
//   ready, and loads the next request's beats as its last beat leaves.
//   Requests with no result (queued data, unexpected events) load no beats
//   and do not hold up the next request.
//   While res is stalled, results hold in the buffer, the intake queue fills
//   and then req drops ready.
//   Reset empties all queues, clears the fault and returns to idle. After
//   a fault every request answers with a fault status until reset.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer_unit import i2c_ras_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	i2c_ras_req_if.sink   req,
	i2c_ras_res_if.source res
);

	fq_head_t    head;
	logic        pop;
	logic        can_load;
	res_bundle_t bundle;

	i2c_ras_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.head   (head)
	);

	i2c_ras_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.can_load (can_load),
		.bundle   (bundle)
	);

	i2c_ras_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.bundle   (bundle),
		.can_load (can_load),
		.res      (res)
	);

endmodule
